[design/cma_pkg.sv]
// Shared types, codes and fixed-point constants of the conductivity meter averager.
// No dependencies; every other design file depends on this package.
package cma_pkg;

    // Build-time defaults
    localparam int MAX_WINDOW_DEF = 64;
    localparam int ADC_BITS_DEF   = 10;

    // Field widths
    localparam int WIN_W    = 7;
    localparam int FUNC_W   = 2;
    localparam int TEMP_W   = 12;
    localparam int STATUS_W = 2;
    localparam int VOLT_W   = 13;
    localparam int COMP_W   = 15;
    localparam int EC_W     = 15;

    localparam logic [WIN_W-1:0] WIN_RESET = 7'd20;

    // Item codes
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEMP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd2;

    // Millivolt conversion
    localparam int VOLT_FULL_SCALE = 5000;

    // Coefficient K = 160000 + 185*(T16 - 400), clamped to 40000
    localparam int K_W     = 19;
    localparam int KR_W    = 21;
    localparam int K_BASE  = 160000;
    localparam int K_SLOPE = 185;
    localparam int T_REF16 = 400;
    localparam int K_MIN   = 40000;

    // Quotient of (V*160000 << 9) / K
    localparam int NUM_W     = 30;
    localparam int Q_W       = 24;
    localparam int Q_CNT_W   = 5;
    localparam int FRAC_BITS = 9;

    localparam logic [Q_W-1:0] Q_BELOW = Q_W'(150 * 512);
    localparam logic [Q_W-1:0] Q_ABOVE = Q_W'(3300 * 512);
    localparam logic [Q_W-1:0] Q_SEG1  = Q_W'(448 * 512);
    localparam logic [Q_W-1:0] Q_SEG2  = Q_W'(1457 * 512);

    localparam logic [COMP_W-1:0] COMP_SAT = 15'd20000;
    localparam logic [EC_W-1:0]   EC_SAT   = 15'd20000;

    // Segment map, gains and offsets in hundredths, offsets pre-scaled by 256
    localparam int CQ_W   = 20;
    localparam int GAIN_W = 10;
    localparam int PROD_W = 30;
    localparam int OFF_W  = 27;
    localparam int T_W    = 31;

    localparam logic [GAIN_W-1:0] GAIN_SEG1 = 10'd684;
    localparam logic [GAIN_W-1:0] GAIN_SEG2 = 10'd698;
    localparam logic [GAIN_W-1:0] GAIN_SEG3 = 10'd530;

    localparam logic signed [OFF_W-1:0] OFF_SEG1 = OFF_W'(-6432 * 256);
    localparam logic signed [OFF_W-1:0] OFF_SEG2 = OFF_W'(-12700 * 256);
    localparam logic signed [OFF_W-1:0] OFF_SEG3 = OFF_W'(227800 * 256);

    // Rounding and divide by 25600 = (>> 8) then reciprocal of 100
    localparam int ROUND_HALF  = 12800;
    localparam int ROUND_SHIFT = 8;
    localparam int W_W         = 22;
    localparam int ECP_W       = 44;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_100   = 2684355;

    typedef struct packed {
        logic accept;
        logic acc;
        logic avg_load;
        logic scale;
        logic div_q;
        logic seg;
        logic ec;
        logic out_load;
    } cma_cmd_t;

    typedef struct packed {
        logic div_busy;
    } cma_stat_t;

endpackage

[design/cma_if.sv]
// Valid/ready channel interfaces for input items and result words.
// Depends on cma_pkg for widths and defaults.
interface cma_in_if #(parameter int ADC_BITS = cma_pkg::ADC_BITS_DEF) ();
    import cma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [ADC_BITS-1:0]        adc_sample;
    logic signed [TEMP_W-1:0]   temperature_sixteenths;

    modport source (output valid, func, adc_sample, temperature_sixteenths, input ready);
    modport sink   (input valid, func, adc_sample, temperature_sixteenths, output ready);
endinterface

interface cma_out_if #(parameter int ADC_BITS = cma_pkg::ADC_BITS_DEF) ();
    import cma_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [EC_W-1:0]        conductivity_us_cm;
    logic [ADC_BITS-1:0]    average_raw;
    logic [VOLT_W-1:0]      voltage_mv;
    logic [COMP_W-1:0]      compensated_mv;

    modport source (output valid, status, conductivity_us_cm, average_raw, voltage_mv,
                    compensated_mv, input ready);
    modport sink   (input valid, status, conductivity_us_cm, average_raw, voltage_mv,
                    compensated_mv, output ready);
endinterface

[design/conductivity_meter_averager.sv]
// Top level of the conductivity meter averager: controller plus datapath.
// Depends on cma_pkg, cma_if, cma_ctrl and cma_datapath.
//
// Usage:
//   in_ch carries one word per item: func selects an ADC sample, a temperature
//   reading or a report request. out_ch carries one result word per report:
//   status, conductivity in uS/cm, the raw average, millivolts and the
//   temperature compensated millivolts.
//   cfg_we/cfg_wdata write the window length; a write clears the sample ring,
//   running total, ring position and average. Write only while idle.
// Timing:
//   A temperature item is latched as it is taken. A sample is held by the
//   bit-serial divide of the running total by the window length. A report is
//   held by the 24-step divide by the temperature coefficient; the result word
//   appears on out_ch after that.
//   One item is worked on at a time; in_ch.ready is high only when idle.
// Reset:
//   rst_n clears the ring (per-entry valid bits), total, position, average and
//   latched temperature, and sets the window length to 20.
// Stall:
//   The result word sits in an output register; a new item is taken while it
//   waits. A report that finishes while the register is still full holds
//   until out_ch.ready frees it.
module conductivity_meter_averager #(
    parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF,
    parameter int ADC_BITS   = cma_pkg::ADC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cma_pkg::WIN_W-1:0] cfg_wdata,
    cma_in_if.sink                    in_ch,
    cma_out_if.source                 out_ch
);
    import cma_pkg::*;

    cma_cmd_t  cmd;    // controller to datapath
    cma_stat_t stat;   // datapath to controller

    // Sequence items: accept, ring update or report steps, result load
    cma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd)
    );

    // Hold the moving-average state and do the arithmetic
    cma_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .ADC_BITS   (ADC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (in_ch.func),
        .in_sample  (in_ch.adc_sample),
        .in_temp    (in_ch.temperature_sixteenths),
        .out_status (out_ch.status),
        .out_ec     (out_ch.conductivity_us_cm),
        .out_avg    (out_ch.average_raw),
        .out_volt   (out_ch.voltage_mv),
        .out_comp   (out_ch.compensated_mv)
    );
endmodule

[design/cma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on cma_pkg for default sizes only.
module cma_ram #(
    parameter int WIDTH = cma_pkg::ADC_BITS_DEF,
    parameter int DEPTH = cma_pkg::MAX_WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[design/cma_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the average and the
// compensation paths. Depends on cma_pkg for default widths.
module cma_div #(
    parameter int DVW = cma_pkg::K_W,
    parameter int QW  = cma_pkg::Q_W,
    parameter int CW  = cma_pkg::Q_CNT_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] rem_init,   // upper dividend bits, below divisor
    input  logic [DVW-1:0] divisor,
    input  logic [QW-1:0]  bits_init,  // lower dividend bits, MSB aligned
    input  logic [CW-1:0]  count,
    output logic           busy,
    output logic [QW-1:0]  quotient,
    output logic           rem_zero
);
    logic           busy_reg, busy_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg;
    logic [QW-1:0]  q_reg, q_next;
    logic [DVW+1:0] diff;
    logic           ge;

    always_comb
    begin
        diff      = {1'b0, rem_reg, q_reg[QW-1]} - {2'b00, dvs_reg};
        ge        = ~diff[DVW+1];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = count;
            rem_next  = rem_init;
            q_next    = bits_init;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVW-1:0] : {rem_reg[DVW-2:0], q_reg[QW-1]};
            q_next   = {q_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
    assign rem_zero = (rem_reg == '0);
endmodule

[design/cma_datapath.sv]
// Datapath: sample ring, running total, average, compensation and segment map.
// Depends on cma_pkg, cma_ram and cma_div; driven by commands from cma_ctrl.
module cma_datapath #(
    parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF,
    parameter int ADC_BITS   = cma_pkg::ADC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cma_pkg::WIN_W-1:0]         cfg_wdata,
    input  cma_pkg::cma_cmd_t                 cmd,
    output cma_pkg::cma_stat_t                stat,
    input  logic [cma_pkg::FUNC_W-1:0]        in_func,
    input  logic [ADC_BITS-1:0]               in_sample,
    input  logic signed [cma_pkg::TEMP_W-1:0] in_temp,
    output logic [cma_pkg::STATUS_W-1:0]      out_status,
    output logic [cma_pkg::EC_W-1:0]          out_ec,
    output logic [ADC_BITS-1:0]               out_avg,
    output logic [cma_pkg::VOLT_W-1:0]        out_volt,
    output logic [cma_pkg::COMP_W-1:0]        out_comp
);
    import cma_pkg::*;

    localparam int PW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int TW = ADC_BITS + LW;

    // Architectural state
    logic [WIN_W-1:0]         window_reg;
    logic [MAX_WINDOW-1:0]    valid_reg;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [TW-1:0]            total_reg, total_next;
    logic [ADC_BITS-1:0]      avg_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    // Working registers
    logic [ADC_BITS-1:0]      sample_reg;
    logic [VOLT_W-1:0]        volt_reg, volt_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [COMP_W-1:0]        comp_reg, comp_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic signed [OFF_W-1:0]  off_reg, off_next;
    logic [W_W-1:0]           w_reg, w_next;

    // Result word
    logic [STATUS_W-1:0]      out_status_reg;
    logic [EC_W-1:0]          out_ec_reg, ec_next;
    logic [ADC_BITS-1:0]      out_avg_reg;
    logic [VOLT_W-1:0]        out_volt_reg;
    logic [COMP_W-1:0]        out_comp_reg;

    logic [LW-1:0]            win_len;
    logic [ADC_BITS-1:0]      ram_rdata;
    logic [ADC_BITS-1:0]      old_sample;
    logic [PW:0]              pos_inc;

    logic                     div_start, div_busy, div_rem_zero;
    logic [K_W-1:0]           div_rem_init, div_divisor;
    logic [Q_W-1:0]           div_bits, quotient;
    logic [Q_CNT_W-1:0]       div_count;
    logic [NUM_W-1:0]         num;

    logic [ADC_BITS+VOLT_W-1:0] volt_prod;
    logic signed [TEMP_W:0]     t_diff;
    logic signed [KR_W-1:0]     k_raw;

    logic [GAIN_W-1:0]        gain;
    logic [Q_W:0]             cq_sum;
    logic signed [T_W-1:0]    t_sum;
    logic [PROD_W-1:0]        pos_val, round_sum;
    logic [ECP_W-1:0]         ec_prod;
    logic [ECP_W-RECIP_SHIFT-1:0] ec_quo;

    // Window length as used: zero acts as one, oversize clamps to the ring depth
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_len = LW'(1);
        end
        else if (int'(window_reg) > MAX_WINDOW)
        begin
            win_len = LW'(MAX_WINDOW);
        end
        else
        begin
            win_len = LW'(window_reg);
        end
    end

    cma_ram #(.WIDTH(ADC_BITS), .DEPTH(MAX_WINDOW)) u_ring (
        .clk   (clk),
        .we    (cmd.acc),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // Ring update
    always_comb
    begin
        old_sample = valid_reg[pos_reg] ? ram_rdata : '0;
        total_next = total_reg - TW'(old_sample) + TW'(sample_reg);
        pos_inc    = {1'b0, pos_reg} + (PW+1)'(1);
        pos_next   = (pos_inc >= (PW+1)'(win_len)) ? '0 : pos_inc[PW-1:0];
    end

    // Divider operands: average of the ring, or the scaled compensation quotient
    always_comb
    begin
        num       = NUM_W'(volt_reg) * NUM_W'(K_BASE);
        div_start = cmd.acc | cmd.div_q;
        if (cmd.div_q)
        begin
            div_rem_init = K_W'(num[NUM_W-1:Q_W-FRAC_BITS]);
            div_bits     = {num[Q_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
            div_divisor  = k_reg;
            div_count    = Q_CNT_W'(Q_W);
        end
        else
        begin
            div_rem_init = K_W'(total_next[TW-1:ADC_BITS]);
            div_bits     = {total_next[ADC_BITS-1:0], (Q_W-ADC_BITS)'(0)};
            div_divisor  = K_W'(win_len);
            div_count    = Q_CNT_W'(ADC_BITS);
        end
    end

    cma_div #(.DVW(K_W), .QW(Q_W), .CW(Q_CNT_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .divisor   (div_divisor),
        .bits_init (div_bits),
        .count     (div_count),
        .busy      (div_busy),
        .quotient  (quotient),
        .rem_zero  (div_rem_zero)
    );

    assign stat.div_busy = div_busy;

    // Millivolts and temperature coefficient
    always_comb
    begin
        volt_prod = (ADC_BITS+VOLT_W)'(avg_reg) * (ADC_BITS+VOLT_W)'(VOLT_FULL_SCALE);
        volt_next = volt_prod[ADC_BITS+VOLT_W-1:ADC_BITS];
        t_diff    = (TEMP_W+1)'(temp_reg) - (TEMP_W+1)'(T_REF16);
        k_raw     = KR_W'(t_diff) * KR_W'(K_SLOPE) + KR_W'(K_BASE);
        k_next    = (k_raw < KR_W'(K_MIN)) ? K_W'(K_MIN) : k_raw[K_W-1:0];
    end

    // Range check and segment select on q = floor(c * 512)
    always_comb
    begin
        if (quotient[Q_W-1:FRAC_BITS] > COMP_SAT)
        begin
            comp_next = COMP_SAT;
        end
        else
        begin
            comp_next = quotient[Q_W-1:FRAC_BITS];
        end

        if (quotient < Q_BELOW)
        begin
            status_next = STATUS_BELOW;
        end
        else if (quotient > Q_ABOVE || (quotient == Q_ABOVE && !div_rem_zero))
        begin
            status_next = STATUS_ABOVE;
        end
        else
        begin
            status_next = STATUS_VALID;
        end

        if (quotient < Q_SEG1 || (quotient == Q_SEG1 && div_rem_zero))
        begin
            gain     = GAIN_SEG1;
            off_next = OFF_SEG1;
        end
        else if (quotient < Q_SEG2 || (quotient == Q_SEG2 && div_rem_zero))
        begin
            gain     = GAIN_SEG2;
            off_next = OFF_SEG2;
        end
        else
        begin
            gain     = GAIN_SEG3;
            off_next = OFF_SEG3;
        end

        // round to nearest Q8: (q + 1) >> 1
        cq_sum    = {1'b0, quotient} + (Q_W+1)'(1);
        prod_next = PROD_W'(gain) * PROD_W'(cq_sum[CQ_W:1]);
    end

    // Offset, clamp at zero, round and drop the Q8 fraction
    always_comb
    begin
        t_sum     = $signed({1'b0, prod_reg}) + T_W'(off_reg);
        pos_val   = t_sum[T_W-1] ? '0 : t_sum[PROD_W-1:0];
        round_sum = pos_val + PROD_W'(ROUND_HALF);
        w_next    = round_sum[PROD_W-1:ROUND_SHIFT];
    end

    // Divide by 100 through the reciprocal
    always_comb
    begin
        ec_prod = ECP_W'(w_reg) * ECP_W'(RECIP_100);
        ec_quo  = ec_prod[ECP_W-1:RECIP_SHIFT];
        if (status_reg != STATUS_VALID)
        begin
            ec_next = '0;
        end
        else if (ec_quo > (ECP_W-RECIP_SHIFT)'(EC_SAT))
        begin
            ec_next = EC_SAT;
        end
        else
        begin
            ec_next = ec_quo[EC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WIN_RESET;
            valid_reg  <= '0;
            pos_reg    <= '0;
            total_reg  <= '0;
            avg_reg    <= '0;
            temp_reg   <= '0;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_wdata;
            valid_reg  <= '0;
            pos_reg    <= '0;
            total_reg  <= '0;
            avg_reg    <= '0;
        end
        else
        begin
            if (cmd.accept && in_func == FUNC_TEMP)
            begin
                temp_reg <= in_temp;
            end
            if (cmd.acc)
            begin
                valid_reg[pos_reg] <= 1'b1;
                pos_reg            <= pos_next;
                total_reg          <= total_next;
            end
            if (cmd.avg_load)
            begin
                avg_reg <= quotient[ADC_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= in_sample;
        end
        if (cmd.scale)
        begin
            volt_reg <= volt_next;
            k_reg    <= k_next;
        end
        if (cmd.seg)
        begin
            comp_reg   <= comp_next;
            status_reg <= status_next;
            prod_reg   <= prod_next;
            off_reg    <= off_next;
        end
        if (cmd.ec)
        begin
            w_reg <= w_next;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_ec_reg     <= ec_next;
            out_avg_reg    <= avg_reg;
            out_volt_reg   <= volt_reg;
            out_comp_reg   <= comp_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_ec     = out_ec_reg;
    assign out_avg    = out_avg_reg;
    assign out_volt   = out_volt_reg;
    assign out_comp   = out_comp_reg;
endmodule

[design/cma_ctrl.sv]
// Controller state machine: sequences one item at a time through the datapath.
// Depends on cma_pkg for item codes and the command and status structs.
module cma_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [cma_pkg::FUNC_W-1:0] in_func,
    input  logic                       out_ready,
    input  cma_pkg::cma_stat_t         stat,
    output logic                       in_ready,
    output logic                       out_valid,
    output cma_pkg::cma_cmd_t          cmd
);
    import cma_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ACC   = 9'b000000010,
        ST_AVGW  = 9'b000000100,
        ST_SCALE = 9'b000001000,
        ST_DIVQ  = 9'b000010000,
        ST_QUOW  = 9'b000100000,
        ST_SEG   = 9'b001000000,
        ST_EC    = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_func == FUNC_SAMPLE)
                    begin
                        state_next = ST_ACC;
                    end
                    else if (in_func == FUNC_REPORT)
                    begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_AVGW;
            end
            ST_AVGW:
            begin
                if (!stat.div_busy)
                begin
                    cmd.avg_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DIVQ;
            end
            ST_DIVQ:
            begin
                cmd.div_q  = 1'b1;
                state_next = ST_QUOW;
            end
            ST_QUOW:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                cmd.seg    = 1'b1;
                state_next = ST_EC;
            end
            ST_EC:
            begin
                cmd.ec     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

[design/cma_checker.sv]
// Port-level checks on the conductivity meter averager, bound to the top level.
// Depends on cma_pkg for item and status codes.
module cma_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [cma_pkg::FUNC_W-1:0]   in_func,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cma_pkg::STATUS_W-1:0] out_status,
    input logic [cma_pkg::EC_W-1:0]     out_ec,
    input logic [cma_pkg::COMP_W-1:0]   out_comp
);
    import cma_pkg::*;

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A report occupies the block after it is taken
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_func == FUNC_REPORT |=> !in_ready)
        else $error("input taken right after a report");

    // Flagged results carry no conductivity
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != STATUS_VALID |-> out_ec == '0)
        else $error("conductivity nonzero on a flagged result");

    // A valid result lies inside the measuring range
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == STATUS_VALID |->
            out_comp >= COMP_W'(150) && out_comp <= COMP_W'(3300))
        else $error("valid status outside the compensated range");
endmodule

bind conductivity_meter_averager cma_checker u_cma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_func    (in_ch.func),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_ec     (out_ch.conductivity_us_cm),
    .out_comp   (out_ch.compensated_mv)
);

[tb/tb_conductivity_meter_averager.sv]
// Self-checking bench for conductivity_meter_averager: random and directed words on
// in_ch, every result word on out_ch checked against a cycle-free predictor.
// Depends on cma_pkg, cma_if and the design files; reads nothing else.
module tb_conductivity_meter_averager;
    import cma_pkg::*;

    // Selector value that the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Idle time before a window write or after the last result: covers a sample
    // divide and a report with margin.
    localparam int SETTLE_CYCLES = 48;
    // Quiet cycles (no word moves on either channel) before the run is declared hung
    localparam int QUIET_LIMIT   = 4000;
    // Long receiver hold-off, started once this many words have gone in
    localparam int LONG_HOLD_AT  = 190;
    localparam int LONG_HOLD     = 400;

    typedef enum logic [1:0] {ENT_WORD, ENT_WINDOW, ENT_DRAIN} plan_kind_e;

    // One step of the plan: an input word, a window write, or a pause for drain
    typedef struct {
        plan_kind_e               kind;
        logic [FUNC_W-1:0]        func;
        logic [ADC_BITS_DEF-1:0]  adc;
        logic signed [TEMP_W-1:0] temp;
        logic [WIN_W-1:0]         window;
    } plan_step_t;

    // One expected result word
    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [EC_W-1:0]         ec;
        logic [ADC_BITS_DEF-1:0] avg;
        logic [VOLT_W-1:0]       mv;
        logic [COMP_W-1:0]       comp;
    } reading_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [WIN_W-1:0] cfg_wdata;

    cma_in_if  in_ch ();
    cma_out_if out_ch ();

    conductivity_meter_averager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: mirror of the sample ring, its sum and the latched
    // temperature, updated at the same edges where the block sees them.
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]         win_len;
    logic [ADC_BITS_DEF-1:0]  ring_store [MAX_WINDOW_DEF];
    logic [15:0]              ring_sum;
    int                       ring_ptr;
    logic [ADC_BITS_DEF-1:0]  avg_now;
    logic signed [TEMP_W-1:0] temp_now;

    plan_step_t work_plan [$];
    reading_t   readings_due [$];

    int unsigned words_sent;
    int unsigned words_taken;
    int unsigned window_writes;
    int unsigned readings_checked;
    int unsigned readings_flagged;
    int unsigned fail_count;

    // Any window write empties the ring and restarts the average
    function automatic void set_window(logic [WIN_W-1:0] w);
        win_len = w;
        foreach (ring_store[i]) ring_store[i] = '0;
        ring_sum = '0;
        ring_ptr = 0;
        avg_now  = '0;
    endfunction

    // Convert the current average and temperature into one result word
    function automatic reading_t compute_reading();
        reading_t        rd;
        longint unsigned mv, kd, num, comp, cq, clipped, ec;
        longint          k, t;
        mv = (64'(avg_now) * 64'd5000) >> ADC_BITS_DEF;
        // coefficient held as a numerator over 160000, floored at 0.25
        k = 64'sd160000 + 64'sd185 * (longint'(temp_now) - 64'sd400);
        if (k < 40000) k = 40000;
        kd   = k;
        num  = mv * 160000;
        comp = num / kd;
        if (comp > 20000) comp = 20000;
        ec = 0;
        if (num < 150 * kd) begin
            rd.status = STATUS_BELOW;
        end else if (num > 3300 * kd) begin
            rd.status = STATUS_ABOVE;
        end else begin
            rd.status = STATUS_VALID;
            // compensated voltage in Q8, rounded half up
            cq = (num * 512 + kd) / (2 * kd);
            if (num <= 448 * kd)
                t = longint'(684 * cq) - 6432 * 256;
            else if (num <= 1457 * kd)
                t = longint'(698 * cq) - 12700 * 256;
            else
                t = longint'(530 * cq) + 227800 * 256;
            clipped = (t < 0) ? 0 : t;
            ec = (clipped + 12800) / 25600;
            if (ec > 20000) ec = 20000;
        end
        rd.ec   = EC_W'(ec);
        rd.avg  = avg_now;
        rd.mv   = VOLT_W'(mv);
        rd.comp = COMP_W'(comp);
        return rd;
    endfunction

    // Apply one accepted input word to the predictor
    function automatic void update_meter(logic [FUNC_W-1:0] f, logic [ADC_BITS_DEF-1:0] s,
                                         logic signed [TEMP_W-1:0] tmp);
        int eff;
        eff = (win_len == 0) ? 1 : (win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win_len);
        case (f)
            FUNC_SAMPLE: begin
                ring_sum = ring_sum - ring_store[ring_ptr] + s;
                ring_store[ring_ptr] = s;
                ring_ptr = ring_ptr + 1;
                if (ring_ptr >= eff) ring_ptr = 0;
                avg_now = ADC_BITS_DEF'(ring_sum / eff);
            end
            FUNC_TEMP:   temp_now = tmp;
            FUNC_REPORT: readings_due.push_back(compute_reading());
            default:     ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Gap length: mostly none or short, now and then long; none in burst mode
    function automatic int pick_gap(bit bursty);
        int r;
        if (bursty) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic int clamp_adc(int v);
        if (v < 0) return 0;
        if (v > 1023) return 1023;
        return v;
    endfunction

    function automatic void push_word(logic [FUNC_W-1:0] f, int s, int tmp);
        plan_step_t st;
        st.kind   = ENT_WORD;
        st.func   = f;
        st.adc    = ADC_BITS_DEF'(s);
        st.temp   = TEMP_W'(tmp);
        st.window = '0;
        work_plan.push_back(st);
    endfunction

    function automatic void push_pause(plan_kind_e kind, int w);
        plan_step_t st;
        st.kind   = kind;
        st.func   = FUNC_SAMPLE;
        st.adc    = '0;
        st.temp   = '0;
        st.window = WIN_W'(w);
        work_plan.push_back(st);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: change everything at the falling edge. Hold the word
    // until the monitor has seen it taken, then idle for the chosen gap.
    // Window writes and drain points wait until no reading is due and the
    // block has had time to finish a sample that gives no result.
    // ------------------------------------------------------------------
    int gap_left    = 0;
    int settle_left = SETTLE_CYCLES;
    bit in_bursty   = 1'b0;

    always @(negedge clk) begin : word_driver
        plan_step_t st;
        if (rst_n) begin
            if (cfg_we) begin
                cfg_we <= 1'b0;
            end else if (in_ch.valid && words_taken != words_sent) begin
                // hold: the block has not taken the word yet
            end else if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (work_plan.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (work_plan[0].kind == ENT_WORD) begin
                st = work_plan.pop_front();
                in_ch.valid                  <= 1'b1;
                in_ch.func                   <= st.func;
                in_ch.adc_sample             <= st.adc;
                in_ch.temperature_sixteenths <= st.temp;
                words_sent++;
                if (words_sent % 80 == 0) in_bursty = ($urandom_range(0, 2) == 0);
                gap_left = pick_gap(in_bursty);
            end else begin
                // drain point or window write: let the block go quiet first
                in_ch.valid <= 1'b0;
                if (readings_due.size() != 0) begin
                    settle_left = SETTLE_CYCLES;
                end else if (settle_left > 0) begin
                    settle_left = settle_left - 1;
                end else begin
                    st = work_plan.pop_front();
                    if (st.kind == ENT_WINDOW) begin
                        cfg_we    <= 1'b1;
                        cfg_wdata <= st.window;
                    end
                    settle_left = SETTLE_CYCLES;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result acceptor: drop ready for random stretches, with burst periods
    // of none and one long hold-off that backs the block up into in_ch.
    // ------------------------------------------------------------------
    int unsigned ready_ticks    = 0;
    int          stall_left     = 0;
    bit          out_bursty     = 1'b0;
    bit          long_hold_done = 1'b0;

    always @(negedge clk) begin : result_acceptor
        if (rst_n) begin
            ready_ticks++;
            if (ready_ticks % 256 == 0) out_bursty = ($urandom_range(0, 3) == 0);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                out_ch.ready <= 1'b1;
                if (!long_hold_done && words_taken >= LONG_HOLD_AT) begin
                    long_hold_done = 1'b1;
                    stall_left     = LONG_HOLD;
                end else begin
                    stall_left = pick_gap(out_bursty);
                end
            end
        end
    end

    // Input side monitor: advance the predictor at the edge that takes a word
    always @(posedge clk) begin : word_monitor
        if (rst_n) begin
            if (cfg_we) begin
                set_window(cfg_wdata);
                window_writes++;
            end
            if (in_ch.valid && in_ch.ready) begin
                words_taken++;
                update_meter(in_ch.func, in_ch.adc_sample, in_ch.temperature_sixteenths);
            end
        end
    end

    // Output side monitor: compare each taken result word with the oldest due
    always @(posedge clk) begin : result_monitor
        reading_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (readings_due.size() == 0) begin
                fail_count++;
                $error("result word arrived with no reading due");
            end else begin
                want = readings_due.pop_front();
                check_field("status", want.status, out_ch.status);
                check_field("conductivity_us_cm", want.ec, out_ch.conductivity_us_cm);
                check_field("average_raw", want.avg, out_ch.average_raw);
                check_field("voltage_mv", want.mv, out_ch.voltage_mv);
                check_field("compensated_mv", want.comp, out_ch.compensated_mv);
                readings_checked++;
                if (want.status != STATUS_VALID) readings_flagged++;
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    int quiet_cycles = 0;

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles, %0d readings still due",
                         quiet_cycles, readings_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int window_plan [10];
        int level, spread, r, s, tmp;
        rst_n                        = 1'b0;
        cfg_we                       = 1'b0;
        cfg_wdata                    = '0;
        in_ch.valid                  = 1'b0;
        in_ch.func                   = FUNC_SAMPLE;
        in_ch.adc_sample             = '0;
        in_ch.temperature_sixteenths = '0;
        out_ch.ready                 = 1'b0;
        words_sent       = 0;
        words_taken      = 0;
        window_writes    = 0;
        readings_checked = 0;
        readings_flagged = 0;
        fail_count       = 0;
        set_window(WIN_RESET);
        temp_now = '0;

        // Directed: report straight out of reset, an ignored selector with
        // all payload bits set, then window 0 (behaves as 1) so each sample
        // sets the average directly.
        push_word(FUNC_REPORT, 0, 0);
        push_word(FUNC_UNUSED, 1023, -1);
        push_word(FUNC_REPORT, 0, 0);
        push_pause(ENT_WINDOW, 0);
        push_word(FUNC_SAMPLE, 1023, 0);
        push_word(FUNC_REPORT, 0, 0);       // 0 C: coefficient well below 1, above range
        push_word(FUNC_TEMP, 0, 400);
        push_word(FUNC_REPORT, 0, 0);       // full scale at 25 C
        push_word(FUNC_TEMP, 0, 2047);
        push_word(FUNC_REPORT, 0, 0);       // hottest code: upper segment
        push_word(FUNC_TEMP, 0, -2048);
        push_word(FUNC_REPORT, 0, 0);       // coldest code: coefficient clamped
        push_word(FUNC_TEMP, 0, -880);
        push_word(FUNC_REPORT, 0, 0);
        push_word(FUNC_SAMPLE, 0, 0);
        push_word(FUNC_REPORT, 0, 0);       // zero average: below range
        push_word(FUNC_TEMP, 0, 400);
        push_word(FUNC_SAMPLE, 100, 0);
        push_word(FUNC_REPORT, 0, 0);       // middle segment
        push_word(FUNC_SAMPLE, 60, 0);
        push_word(FUNC_REPORT, 0, 0);       // lower segment
        push_word(FUNC_SAMPLE, 31, 0);
        push_word(FUNC_REPORT, 0, 0);       // just above the low limit
        push_word(FUNC_TEMP, 0, 2000);
        push_word(FUNC_REPORT, 0, 0);

        // Random phases, each under its own window length (extremes included:
        // 1, 64 and 127, which behaves as 64). Samples follow a drifting level
        // so the average sweeps the whole range, with spikes to 0 and 1023.
        window_plan = '{1, 64, 127, 20, 2, 8, 33, 0, 64, 0};
        window_plan[7] = $urandom_range(0, 127);
        window_plan[9] = $urandom_range(1, 64);
        foreach (window_plan[p]) begin
            push_pause(ENT_WINDOW, window_plan[p]);
            level  = $urandom_range(0, 1023);
            spread = $urandom_range(0, 300);
            for (int n = 0; n < 128; n++) begin
                if (n == 100) push_pause(ENT_DRAIN, 0);
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    if ($urandom_range(0, 15) == 0) begin
                        s = $urandom_range(0, 1) ? 1023 : 0;
                    end else begin
                        level = clamp_adc(level + int'($urandom_range(0, 80)) - 40);
                        s = clamp_adc(level + int'($urandom_range(0, 2 * spread)) - spread);
                    end
                    push_word(FUNC_SAMPLE, s, $urandom_range(0, 4095));
                end else if (r < 70) begin
                    r = $urandom_range(0, 19);
                    if (r < 14)      tmp = int'($urandom_range(0, 2880)) - 880;
                    else if (r < 19) tmp = int'($urandom_range(0, 4095)) - 2048;
                    else             tmp = 400;
                    push_word(FUNC_TEMP, $urandom_range(0, 1023), tmp);
                end else if (r < 95) begin
                    push_word(FUNC_REPORT, $urandom_range(0, 1023), $urandom_range(0, 4095));
                end else begin
                    push_word(FUNC_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 4095));
                end
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every word to go in and every reading to come out, then
        // give the block time to show any stray result.
        while (work_plan.size() != 0 || words_taken != words_sent || readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d input words under %0d window writes", words_taken,
                 window_writes);
        $display("%0d result words checked, %0d of them flagged out of range",
                 readings_checked, readings_flagged);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
